// ===== hw/rtl/poly_triangle_synth_voices_macros.svh =====
// ============================================================================
// Assertion macros for the triangle synthesizer
// Shared forms for the concurrent checks on the block's ports.
// ============================================================================
`ifndef POLY_TRIANGLE_SYNTH_VOICES_MACROS_SVH
`define POLY_TRIANGLE_SYNTH_VOICES_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTSV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTSV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ptsv_pkg.sv =====
// ============================================================================
// ptsv_pkg
// Types, constants and the pitch table of the triangle synthesizer.
// ============================================================================
`default_nettype none

package ptsv_pkg;

    localparam int VOICE_COUNT = 16;
    localparam int VIDX_W      = $clog2(VOICE_COUNT);
    localparam int PHASE_W     = 24;
    localparam int LEVEL_W     = 25;
    localparam int SAMPLE_RATE = 48000;
    localparam int MAG_W       = 53;
    localparam int MUL_STEPS   = 16;
    localparam int DIV_STEPS   = 45;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << 24;

    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_ALL_OFF  = 2'd2;
    localparam logic [1:0] OP_TICK     = 2'd3;

    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_RELEASE = 2'd1;
    localparam logic [1:0] REG_GAIN    = 2'd2;

    typedef enum logic [1:0] {ST_IDLE, ST_ATTACK, ST_SUSTAIN, ST_RELEASE} vstage_t;
    typedef enum logic [1:0] {TS_IDLE, TS_WALK, TS_DRAIN, TS_SHAPE} top_state_t;
    typedef enum logic [2:0] {SH_IDLE, SH_MUL, SH_DIV, SH_SQ, SH_CUBE, SH_OUT} shp_state_t;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] note;
        logic [6:0] velocity;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               clipped;
    } res_t;

    typedef struct packed {
        logic             go;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [15:0]      gain;
    } shp_req_t;

    typedef struct packed {
        logic done;
        res_t res;
    } shp_rsp_t;

    // Twice the top-octave phase increment, truncated; lower octaves round from it.
    localparam logic [PHASE_W-1:0] PITCH_A2 [12] = '{
        PHASE_W'((64'd548668578  << (PHASE_W - 15)) / SAMPLE_RATE),
        PHASE_W'((64'd581294109  << (PHASE_W - 15)) / SAMPLE_RATE),
        PHASE_W'((64'd615859662  << (PHASE_W - 15)) / SAMPLE_RATE),
        PHASE_W'((64'd652480576  << (PHASE_W - 15)) / SAMPLE_RATE),
        PHASE_W'((64'd691279090  << (PHASE_W - 15)) / SAMPLE_RATE),
        PHASE_W'((64'd732384684  << (PHASE_W - 15)) / SAMPLE_RATE),
        PHASE_W'((64'd775934544  << (PHASE_W - 15)) / SAMPLE_RATE),
        PHASE_W'((64'd822074012  << (PHASE_W - 15)) / SAMPLE_RATE),
        PHASE_W'((64'd870957077  << (PHASE_W - 15)) / SAMPLE_RATE),
        PHASE_W'((64'd922746880  << (PHASE_W - 15)) / SAMPLE_RATE),
        PHASE_W'((64'd977616265  << (PHASE_W - 15)) / SAMPLE_RATE),
        PHASE_W'((64'd1035748353 << (PHASE_W - 15)) / SAMPLE_RATE)
    };

    // Phase increment of a note. The octave comes from a reciprocal multiply,
    // exact for all seven-bit note numbers.
    function automatic logic [PHASE_W-1:0] pitch_inc(input logic [6:0] note);
        logic [12:0]    prod;
        logic [3:0]     oct;
        logic [6:0]     rest;
        logic [3:0]     semi;
        logic [3:0]     k;
        logic [PHASE_W:0] sum;
        prod = 13'(note) * 13'd43;
        oct  = prod[12:9];
        rest = note - 7'(7'(oct) * 7'd12);
        semi = rest[3:0];
        k    = 4'd10 - oct;
        sum  = {1'b0, PITCH_A2[semi]} + ((PHASE_W + 1)'(1) << k);
        return PHASE_W'(sum >> (k + 4'd1));
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/poly_triangle_synth_voices.sv =====
// ============================================================================
// poly_triangle_synth_voices
// Sixteen-voice triangle synthesizer with attack/release envelopes.
// ============================================================================
// Commands are taken when start is high and busy is low. Note-on, note-off
// and all-notes-off take effect in the cycle of the transfer and leave busy
// low, so another command may follow at once. A sample tick raises busy, and
// the block walks the voices one per cycle through a shared envelope and
// multiply pipeline, then drains it. The mix then passes a gain multiplier
// that takes one gain bit per cycle and a restoring divider that yields one
// quotient bit per cycle. Clamp and cubic soft clip follow, in square, cube
// and output steps. In the last busy cycle the sample is on res with done
// high, for exactly one cycle. The receiver cannot stall it, so it must take
// the transfer in that cycle. Configuration writes through the APB port are
// meant for moments when the block is idle.
// ============================================================================
`default_nettype none

module poly_triangle_synth_voices
    import ptsv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire cmd_t        cmd,
    output logic             done,
    output res_t             res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers.
    logic [23:0] attack_reg;
    logic [23:0] release_reg;
    logic [15:0] gain_reg;
    logic        cfg_wr;

    // Voice state.
    vstage_t            stage_reg [VOICE_COUNT];
    logic [6:0]         note_reg  [VOICE_COUNT];
    logic [PHASE_W-1:0] phase_reg [VOICE_COUNT];
    logic [LEVEL_W-1:0] level_reg [VOICE_COUNT];
    logic [6:0]         vel_reg   [VOICE_COUNT];

    top_state_t        state_reg, state_next;
    logic [VIDX_W-1:0] idx_reg;
    logic [1:0]        drain_reg;
    logic              accept;

    // Note-on voice allocation.
    logic              found_idle;
    logic              found_rel;
    logic [VIDX_W-1:0] idle_idx;
    logic [VIDX_W-1:0] rel_idx;
    logic [VIDX_W-1:0] target;

    // Envelope step of the voice under the walk pointer.
    vstage_t            cur_st;
    logic [LEVEL_W-1:0] cur_lv;
    logic [LEVEL_W:0]   atk_sum;
    vstage_t            new_st;
    logic [LEVEL_W-1:0] new_lv;
    logic               contrib;
    logic [15:0]        u;
    logic signed [17:0] tri_w;
    logic signed [42:0] tri_ext;
    logic signed [42:0] lv_ext;

    // Mixing pipeline.
    logic signed [42:0] p1_reg;
    logic [6:0]         vel1_reg;
    logic               p1_vld_reg;
    logic signed [49:0] p1_ext;
    logic signed [49:0] vel_ext;
    logic signed [49:0] p2_reg;
    logic               p2_vld_reg;
    logic signed [53:0] acc_reg;
    logic [53:0]        acc_abs;

    shp_req_t req;
    shp_rsp_t rsp;

    assign accept = start && (state_reg == TS_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_ATTACK:  prdata = {8'd0, attack_reg};
            REG_RELEASE: prdata = {8'd0, release_reg};
            REG_GAIN:    prdata = {16'd0, gain_reg};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= 24'd69905;
            release_reg <= 24'd1398;
            gain_reg    <= 16'd11796;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ATTACK:  attack_reg  <= pwdata[23:0];
                REG_RELEASE: release_reg <= pwdata[23:0];
                REG_GAIN:    gain_reg    <= pwdata[15:0];
                default:     attack_reg  <= attack_reg;
            endcase
        end
    end

    // First idle voice, else first releasing voice, else voice zero.
    always_comb
    begin
        found_idle = 1'b0;
        found_rel  = 1'b0;
        idle_idx   = '0;
        rel_idx    = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--)
        begin
            if (stage_reg[i] == ST_IDLE)
            begin
                found_idle = 1'b1;
                idle_idx   = VIDX_W'(i);
            end
            if (stage_reg[i] == ST_RELEASE)
            begin
                found_rel = 1'b1;
                rel_idx   = VIDX_W'(i);
            end
        end
        target = found_idle ? idle_idx : (found_rel ? rel_idx : '0);
    end

    // Envelope and triangle of the current voice.
    always_comb
    begin
        cur_st  = stage_reg[idx_reg];
        cur_lv  = level_reg[idx_reg];
        atk_sum = (LEVEL_W + 1)'(cur_lv) + (LEVEL_W + 1)'(attack_reg);
        new_st  = cur_st;
        new_lv  = cur_lv;
        contrib = 1'b0;
        case (cur_st)
            ST_ATTACK:
            begin
                contrib = 1'b1;
                if (atk_sum >= (LEVEL_W + 1)'(LEVEL_ONE))
                begin
                    new_lv = LEVEL_ONE;
                    new_st = ST_SUSTAIN;
                end
                else
                begin
                    new_lv = atk_sum[LEVEL_W-1:0];
                end
            end
            ST_SUSTAIN:
            begin
                contrib = 1'b1;
            end
            ST_RELEASE:
            begin
                if (cur_lv <= LEVEL_W'(release_reg))
                begin
                    new_lv = '0;
                    new_st = ST_IDLE;
                end
                else
                begin
                    contrib = 1'b1;
                    new_lv  = cur_lv - LEVEL_W'(release_reg);
                end
            end
            default:
            begin
                contrib = 1'b0;
            end
        endcase
        u = phase_reg[idx_reg][PHASE_W-1 -: 16];
        if (!u[15])
        begin
            tri_w = $signed({2'b00, u[14:0], 1'b0}) - 18'sd32768;
        end
        else
        begin
            tri_w = 18'sd98304 - $signed({1'b0, u, 1'b0});
        end
        tri_ext = 43'(tri_w);
        lv_ext  = $signed({18'd0, new_lv});
        p1_ext  = 50'(p1_reg);
        vel_ext = $signed({43'd0, vel1_reg});
        acc_abs = acc_reg[53] ? 54'(-acc_reg) : 54'(acc_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TS_IDLE:  if (accept && cmd.op == OP_TICK) state_next = TS_WALK;
            TS_WALK:  if (idx_reg == VIDX_W'(VOICE_COUNT - 1)) state_next = TS_DRAIN;
            TS_DRAIN: if (drain_reg == 2'd2) state_next = TS_SHAPE;
            TS_SHAPE: if (rsp.done) state_next = TS_IDLE;
            default:  state_next = TS_IDLE;
        endcase
    end

    always_comb
    begin
        busy     = (state_reg != TS_IDLE);
        req.go   = (state_reg == TS_DRAIN) && (drain_reg == 2'd2);
        req.neg  = acc_reg[53];
        req.mag  = acc_abs[MAG_W-1:0];
        req.gain = gain_reg;
        done     = rsp.done;
        res      = rsp.res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= TS_IDLE;
            idx_reg    <= '0;
            drain_reg  <= '0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                stage_reg[i] <= ST_IDLE;
            end
        end
        else
        begin
            state_reg  <= state_next;
            p1_vld_reg <= (state_reg == TS_WALK) && contrib;
            p2_vld_reg <= p1_vld_reg;
            idx_reg    <= (state_reg == TS_WALK) ? idx_reg + VIDX_W'(1) : '0;
            drain_reg  <= (state_reg == TS_DRAIN) ? drain_reg + 2'd1 : '0;
            if (accept)
            begin
                case (cmd.op)
                    OP_NOTE_ON:
                    begin
                        stage_reg[target] <= ST_ATTACK;
                    end
                    OP_NOTE_OFF:
                    begin
                        for (int i = 0; i < VOICE_COUNT; i++)
                        begin
                            if (note_reg[i] == cmd.note &&
                                (stage_reg[i] == ST_ATTACK || stage_reg[i] == ST_SUSTAIN))
                            begin
                                stage_reg[i] <= ST_RELEASE;
                            end
                        end
                    end
                    OP_ALL_OFF:
                    begin
                        for (int i = 0; i < VOICE_COUNT; i++)
                        begin
                            if (stage_reg[i] != ST_IDLE)
                            begin
                                stage_reg[i] <= ST_RELEASE;
                            end
                        end
                    end
                    default:
                    begin
                        stage_reg[0] <= stage_reg[0];
                    end
                endcase
            end
            else if (state_reg == TS_WALK)
            begin
                stage_reg[idx_reg] <= new_st;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.op == OP_NOTE_ON)
        begin
            note_reg[target]  <= cmd.note;
            vel_reg[target]   <= cmd.velocity;
            phase_reg[target] <= '0;
            level_reg[target] <= '0;
        end
        else if (state_reg == TS_WALK)
        begin
            level_reg[idx_reg] <= new_lv;
            if (contrib)
            begin
                phase_reg[idx_reg] <= phase_reg[idx_reg] + pitch_inc(note_reg[idx_reg]);
            end
        end
        p1_reg   <= tri_ext * lv_ext;
        vel1_reg <= vel_reg[idx_reg];
        p2_reg   <= p1_ext * vel_ext;
        if (accept)
        begin
            acc_reg <= '0;
        end
        else if (p2_vld_reg)
        begin
            acc_reg <= acc_reg + 54'(p2_reg);
        end
    end

    ptsv_shaper u_shaper (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ptsv_shaper.sv =====
// ============================================================================
// ptsv_shaper
// Gain, bit-serial divide, clamp and cubic soft clip of the voice mix.
// ============================================================================
`default_nettype none

module ptsv_shaper
    import ptsv_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire shp_req_t req,
    output shp_rsp_t      rsp
);

    shp_state_t state_reg, state_next;

    logic [42:0] m_reg;
    logic [15:0] g_reg;
    logic [58:0] prod_reg;
    logic [58:0] prod_next;
    logic [5:0]  cnt_reg;
    logic [44:0] quo_reg;
    logic [6:0]  rem_reg;
    logic [7:0]  div_r;
    logic        div_bit;
    logic [59:0] rounded;
    logic [30:0] s_reg;
    logic [30:0] s_c;
    logic        clip_c;
    logic        clip_reg;
    logic [61:0] sq_prod;
    logic [61:0] cube_prod;
    logic [30:0] sq_reg;
    logic [30:0] cube_reg;
    logic [32:0] y_c;
    logic [16:0] q_c;
    logic        neg_reg;
    logic        done_reg;
    res_t        res_reg;
    res_t        res_c;

    localparam logic [30:0] Q30_ONE = 31'(1) << 30;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SH_IDLE: if (req.go) state_next = SH_MUL;
            SH_MUL:  if (cnt_reg == 6'(MUL_STEPS - 1)) state_next = SH_DIV;
            SH_DIV:  if (cnt_reg == 6'(DIV_STEPS - 1)) state_next = SH_SQ;
            SH_SQ:   state_next = SH_CUBE;
            SH_CUBE: state_next = SH_OUT;
            SH_OUT:  state_next = SH_IDLE;
            default: state_next = SH_IDLE;
        endcase
    end

    always_comb
    begin
        prod_next = (prod_reg << 1) + (g_reg[15] ? 59'(m_reg) : 59'd0);
        rounded   = 60'(prod_next) + (60'd127 << 14);
        div_r     = {rem_reg, quo_reg[44]};
        div_bit   = (div_r >= 8'd127);
        clip_c    = (quo_reg > 45'(Q30_ONE));
        s_c       = clip_c ? Q30_ONE : quo_reg[30:0];
        sq_prod   = 62'(s_c) * 62'(s_c) + (62'd1 << 29);
        cube_prod = 62'(sq_reg) * 62'(s_reg) + (62'd1 << 29);
        y_c       = (33'(s_reg) * 33'd3 - 33'(cube_reg)) >> 1;
        q_c       = 17'((y_c + (33'd1 << 14)) >> 15);
        res_c.clipped = clip_reg;
        if (neg_reg)
        begin
            res_c.sample = 16'(-$signed(q_c));
        end
        else
        begin
            res_c.sample = (q_c > 17'd32767) ? 16'sd32767 : $signed(q_c[15:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == SH_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            SH_IDLE:
            begin
                m_reg    <= req.mag[MAG_W-1:10];
                g_reg    <= req.gain;
                neg_reg  <= req.neg;
                prod_reg <= '0;
                cnt_reg  <= '0;
            end
            SH_MUL:
            begin
                prod_reg <= prod_next;
                g_reg    <= g_reg << 1;
                cnt_reg  <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(MUL_STEPS - 1))
                begin
                    quo_reg <= rounded[59:15];
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end
            end
            SH_DIV:
            begin
                rem_reg <= div_bit ? 7'(div_r - 8'd127) : div_r[6:0];
                quo_reg <= {quo_reg[43:0], div_bit};
                cnt_reg <= cnt_reg + 6'd1;
            end
            SH_SQ:
            begin
                s_reg    <= s_c;
                clip_reg <= clip_c;
                sq_reg   <= sq_prod[60:30];
            end
            SH_CUBE:
            begin
                cube_reg <= cube_prod[60:30];
            end
            SH_OUT:
            begin
                res_reg <= res_c;
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    always_comb
    begin
        rsp.done = done_reg;
        rsp.res  = res_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ptsv_checker.sv =====
// ============================================================================
// ptsv_checker
// Port-level checks of the command and result timing.
// ============================================================================
`default_nettype none
`include "poly_triangle_synth_voices_macros.svh"

module ptsv_checker
    import ptsv_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire cmd_t cmd,
    input wire logic done
);

    // A result only appears while a tick is in progress.
    `PTSV_ASSERT_SAME(a_done_busy, clk, rst_n, done, busy, "result outside a tick")
    // A tick transfer starts work.
    `PTSV_ASSERT_NEXT(a_tick_busy, clk, rst_n, start && !busy && cmd.op == OP_TICK, busy, "tick did not start")
    // Note events complete in the cycle of their transfer.
    `PTSV_ASSERT_NEXT(a_evt_free, clk, rst_n, start && !busy && cmd.op != OP_TICK, !busy && !done, "event held the block")
    // The block is free again right after the result.
    `PTSV_ASSERT_NEXT(a_done_free, clk, rst_n, done, !busy && !done, "block stayed busy after result")

endmodule

bind poly_triangle_synth_voices ptsv_checker u_ptsv_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done)
);

`default_nettype wire

// ===== tb/poly_triangle_synth_voices_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Testbench of the sixteen-voice triangle synthesizer
// Drives note events and sample ticks through the command port and writes
// the envelope and gain registers over APB. A predictor that works out every
// expected sample runs alongside. Each result transfer is checked field by
// field against the oldest expected sample.
// ============================================================================
`default_nettype none

module poly_triangle_synth_voices_test;
    import ptsv_pkg::*;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  SETTLE_CYCLES  = 200;
    localparam longint unsigned PH_MASK = (64'd1 << 24) - 1;
    localparam longint unsigned Q30     = 64'd1 << 30;

    // Top octave of the pitch table in Q16 Hz, notes 120 to 131.
    localparam longint unsigned TOP_OCTAVE [12] = '{
        64'd548668578, 64'd581294109, 64'd615859662, 64'd652480576,
        64'd691279090, 64'd732384684, 64'd775934544, 64'd822074012,
        64'd870957077, 64'd922746880, 64'd977616265, 64'd1035748353
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        done;
    res_t        res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    poly_triangle_synth_voices u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 clk = ~clk;

    // Mirror of the synthesizer: register copies and per-voice state.
    longint unsigned env_attack;
    longint unsigned env_release;
    longint unsigned out_gain;
    vstage_t         v_stage [VOICE_COUNT];
    logic [6:0]      v_note  [VOICE_COUNT];
    longint unsigned v_phase [VOICE_COUNT];
    longint unsigned v_level [VOICE_COUNT];
    longint unsigned v_vel   [VOICE_COUNT];

    res_t       expected_samples [$];
    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         sender_idle_pct = 0;
    logic [6:0] held_notes [$];

    function automatic longint unsigned note_phase_step(input logic [6:0] n);
        longint unsigned num;
        longint unsigned den;
        num = TOP_OCTAVE[n % 12] << 24;
        den = (64'd48000 << 16) << (10 - (n / 12));
        return ((num + den / 2) / den) & PH_MASK;
    endfunction

    function automatic longint triangle_of(input longint unsigned ph);
        longint u;
        u = longint'((ph & PH_MASK) >> 8);
        return (u < 32768) ? (2 * u - 32768) : (98304 - 2 * u);
    endfunction

    // Applies one accepted command to the mirror; a tick queues its sample.
    task automatic predict_command(input cmd_t c);
        int              slot;
        longint          acc;
        logic            neg;
        longint unsigned mag, s, s2, s3, y, q;
        res_t            r;
        slot = -1;
        acc  = 0;
        case (c.op)
            OP_NOTE_ON:
            begin
                for (int i = 0; i < VOICE_COUNT && slot < 0; i++)
                    if (v_stage[i] == ST_IDLE) slot = i;
                for (int i = 0; i < VOICE_COUNT && slot < 0; i++)
                    if (v_stage[i] == ST_RELEASE) slot = i;
                // With every voice held, voice 0 is stolen.
                if (slot < 0) slot = 0;
                v_note[slot]  = c.note;
                v_vel[slot]   = c.velocity;
                v_phase[slot] = 0;
                v_level[slot] = 0;
                v_stage[slot] = ST_ATTACK;
            end
            OP_NOTE_OFF:
            begin
                for (int i = 0; i < VOICE_COUNT; i++)
                    if (v_note[i] == c.note &&
                        (v_stage[i] == ST_ATTACK || v_stage[i] == ST_SUSTAIN))
                        v_stage[i] = ST_RELEASE;
            end
            OP_ALL_OFF:
            begin
                for (int i = 0; i < VOICE_COUNT; i++)
                    if (v_stage[i] != ST_IDLE) v_stage[i] = ST_RELEASE;
            end
            default:
            begin
                for (int i = 0; i < VOICE_COUNT; i++) begin
                    if (v_stage[i] == ST_IDLE) continue;
                    if (v_stage[i] == ST_ATTACK) begin
                        v_level[i] += env_attack;
                        if (v_level[i] >= (64'd1 << 24)) begin
                            v_level[i] = 64'd1 << 24;
                            v_stage[i] = ST_SUSTAIN;
                        end
                    end else if (v_stage[i] == ST_RELEASE) begin
                        // A voice that runs out goes idle and keeps its phase.
                        if (v_level[i] <= env_release) begin
                            v_level[i] = 0;
                            v_stage[i] = ST_IDLE;
                            continue;
                        end
                        v_level[i] -= env_release;
                    end
                    acc += triangle_of(v_phase[i]) * longint'(v_level[i]) *
                           longint'(v_vel[i]);
                    v_phase[i] = (v_phase[i] + note_phase_step(v_note[i])) & PH_MASK;
                end
                neg = acc < 0;
                mag = neg ? longint'(-acc) : acc;
                s = ((mag >> 10) * out_gain + (64'd127 << 14)) / (64'd127 << 15);
                r.clipped = 1'b0;
                if (s > Q30) begin
                    s = Q30;
                    r.clipped = 1'b1;
                end
                s2 = (s * s + (64'd1 << 29)) >> 30;
                s3 = (s2 * s + (64'd1 << 29)) >> 30;
                y  = (3 * s - s3) >> 1;
                q  = (y + (64'd1 << 14)) >> 15;
                if (neg) r.sample = -16'(q);
                else     r.sample = (q > 32767) ? 16'sd32767 : 16'(q);
                expected_samples.push_back(r);
            end
        endcase
    endtask

    // Sends one command. start stays high after the transfer unless the
    // sender decides to idle, so commands can follow back to back.
    task automatic send_command(input logic [1:0] op, input logic [6:0] note,
                                input logic [6:0] vel);
        cmd_t c;
        c.op = op;
        c.note = note;
        c.velocity = vel;
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        predict_command(c);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            cmd   <= cmd_t'($urandom);
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Waits for the block to go idle, then writes one register over APB.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        start <= 1'b0;
        wait (expected_samples.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ATTACK:  env_attack  = val & 32'hFF_FFFF;
            REG_RELEASE: env_release = val & 32'hFF_FFFF;
            REG_GAIN:    out_gain    = val & 32'hFFFF;
            default: ;
        endcase
    endtask

    task automatic tick_run(input int n);
        repeat (n) send_command(OP_TICK, 7'($urandom), 7'($urandom));
    endtask

    // Silence after reset, field extremes and a full chord with stealing.
    task automatic test_directed;
        tick_run(1);
        send_command(OP_NOTE_ON, 7'd0, 7'd127);
        send_command(OP_NOTE_ON, 7'd127, 7'd0);
        send_command(OP_NOTE_ON, 7'd69, 7'd1);
        tick_run(3);
        send_command(OP_NOTE_OFF, 7'd0, 7'd0);
        tick_run(2);
        send_command(OP_ALL_OFF, 7'd127, 7'd127);
        tick_run(2);
        // Seventeen note-ons: the last one takes voice 0 back.
        for (int i = 0; i < 17; i++)
            send_command(OP_NOTE_ON, 7'(40 + 5 * i), 7'd127);
        tick_run(2);
    endtask

    // Full gain and instant envelopes drive the mix into the clamp, then the
    // slowest settings check the long ramps.
    task automatic test_register_extremes;
        write_register(REG_GAIN, 32'h0000_FFFF);
        write_register(REG_ATTACK, 32'h00FF_FFFF);
        write_register(REG_RELEASE, 32'h00FF_FFFF);
        for (int i = 0; i < VOICE_COUNT; i++)
            send_command(OP_NOTE_ON, 7'(60 + (i % 3) * 12), 7'd127);
        tick_run(12);
        send_command(OP_ALL_OFF, 7'd0, 7'd0);
        tick_run(3);
        write_register(REG_GAIN, 32'h0000_0000);
        write_register(REG_ATTACK, 32'h0000_0001);
        write_register(REG_RELEASE, 32'h0000_0001);
        send_command(OP_NOTE_ON, 7'd90, 7'd100);
        tick_run(3);
        write_register(REG_GAIN, 32'd40000);
        tick_run(2);
    endtask

    // Half of the steps are ticks over a changing chord; note-offs mostly name held notes.
    task automatic test_random(input int n);
        int         pick;
        logic [6:0] nt;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                tick_run(1);
            end else if (pick < 78) begin
                nt = 7'($urandom);
                held_notes.push_back(nt);
                if (held_notes.size() > 20) void'(held_notes.pop_front());
                send_command(OP_NOTE_ON, nt, 7'($urandom));
            end else if (pick < 95) begin
                if (held_notes.size() > 0 && $urandom_range(3) != 0)
                    nt = held_notes[$urandom_range(held_notes.size() - 1)];
                else
                    nt = 7'($urandom);
                send_command(OP_NOTE_OFF, nt, 7'($urandom));
            end else begin
                send_command(OP_ALL_OFF, 7'($urandom), 7'($urandom));
            end
        end
    endtask

    // Each result transfer lasts one cycle and is taken at the edge ending it.
    always @(posedge clk) begin
        res_t want;
        if (rst_n && done) begin
            if (expected_samples.size() == 0) begin
                $error("result transfer with no sample expected: sample %0d", res.sample);
                mismatches++;
            end else begin
                want = expected_samples.pop_front();
                if (res.sample !== want.sample) begin
                    $error("sample: expected %0d, got %0d", want.sample, res.sample);
                    mismatches++;
                end
                if (res.clipped !== want.clipped) begin
                    $error("clipped: expected %0b, got %0b", want.clipped, res.clipped);
                    mismatches++;
                end
            end
        end
    end

    // Ends the run when no transfer of either kind happens for too long.
    always @(posedge clk) begin
        if ((start && !busy) || done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        rst_n   <= 1'b0;
        start   <= 1'b0;
        cmd     <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        env_attack  = 69905;
        env_release = 1398;
        out_gain    = 11796;
        for (int i = 0; i < VOICE_COUNT; i++) begin
            v_stage[i] = ST_IDLE;
            v_note[i]  = '0;
            v_phase[i] = 0;
            v_level[i] = 0;
            v_vel[i]   = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_extremes();

        // Three random phases: sender idles at times, more often, then never.
        write_register(REG_ATTACK, 32'd69905);
        write_register(REG_RELEASE, 32'd1398);
        write_register(REG_GAIN, 32'd11796);
        sender_idle_pct = 34;
        test_random(110);
        write_register(REG_ATTACK, 32'd500000);
        write_register(REG_RELEASE, 32'd300000);
        write_register(REG_GAIN, 32'd65535);
        sender_idle_pct = 65;
        test_random(110);
        write_register(REG_ATTACK, 32'd3000000);
        write_register(REG_RELEASE, 32'd20000);
        write_register(REG_GAIN, 32'd30000);
        sender_idle_pct = 0;
        test_random(110);

        start <= 1'b0;
        wait (expected_samples.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

// ===== poly_triangle_synth_voices.f =====
+incdir+hw/rtl
hw/rtl/ptsv_pkg.sv
hw/rtl/ptsv_shaper.sv
hw/rtl/poly_triangle_synth_voices.sv
hw/rtl/ptsv_checker.sv
tb/poly_triangle_synth_voices_test.sv
